// ===== hdl/tti_pkg.sv =====
// Shared types, codes and default sizes for the transpose index mapper.
// No dependencies; used by tti_cfg, tti_cell and tensor_transpose_index_map_top.
package tti_pkg;

    localparam int MAX_RANK_DEF    = 4;
    localparam int INDEX_WIDTH_DEF = 32;
    localparam int DIM_WIDTH_DEF   = 16;

    localparam int CFG_INDEX_WIDTH  = 3;
    localparam int RANK_WIDTH       = 3;
    localparam int PERM_WIDTH       = 8;
    localparam int PERM_ENTRY_WIDTH = 2;
    localparam int NUM_SIZE_REGS    = 4;

    localparam logic [PERM_WIDTH-1:0] PERM_RESET = 8'd228;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RANK  = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SIZE0 = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PERM  = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_PERM = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;

    typedef struct packed {
        logic       valid;
        logic [1:0] status;
    } ctl_t;

    typedef struct packed {
        logic busy;
        logic perm_ok;
    } cfg_stat_t;

endpackage

// ===== hdl/tti_cfg.sv =====
// Configuration registers and stride sequencer for the transpose index mapper.
// Depends on tti_pkg; walks one axis per cycle through a pair of multipliers.
module tti_cfg #(
    parameter int MAX_RANK    = tti_pkg::MAX_RANK_DEF,
    parameter int INDEX_WIDTH = tti_pkg::INDEX_WIDTH_DEF,
    parameter int DIM_WIDTH   = tti_pkg::DIM_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    input  logic [tti_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [((DIM_WIDTH > tti_pkg::PERM_WIDTH) ? DIM_WIDTH
                   : tti_pkg::PERM_WIDTH)-1:0]     cfg_data,
    output tti_pkg::cfg_stat_t                     stat,
    output logic [INDEX_WIDTH:0]                   count,
    output logic [INDEX_WIDTH:0]                   out_pitch [MAX_RANK],
    output logic [INDEX_WIDTH-1:0]                 in_weight [MAX_RANK]
);

    localparam int RW = $clog2(MAX_RANK + 1);
    localparam int SW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
    localparam int PW = INDEX_WIDTH + 1 + DIM_WIDTH;
    localparam logic [INDEX_WIDTH:0] SAT = {1'b1, {INDEX_WIDTH{1'b0}}};

    logic [tti_pkg::RANK_WIDTH-1:0]       rank_reg;
    logic [DIM_WIDTH-1:0]                 size_reg [MAX_RANK];
    logic [tti_pkg::PERM_WIDTH-1:0]       perm_reg;

    logic                                 active_reg;
    logic [SW-1:0]                        step_reg;
    logic [INDEX_WIDTH:0]                 acc_out_reg;
    logic [INDEX_WIDTH-1:0]               acc_in_reg;
    logic [INDEX_WIDTH:0]                 out_pitch_reg [MAX_RANK];
    logic [INDEX_WIDTH-1:0]               in_pitch_reg  [MAX_RANK];
    logic [INDEX_WIDTH:0]                 count_reg;
    logic                                 perm_ok_reg;

    logic [tti_pkg::PERM_ENTRY_WIDTH-1:0] perm_ax [MAX_RANK];
    logic [RW-1:0]                        rank_eff;
    logic                                 perm_ok_c;
    logic                                 step_used;
    logic [DIM_WIDTH-1:0]                 ext_o;
    logic [PW-1:0]                        prod_o;
    logic [INDEX_WIDTH:0]                 prod_o_sat;
    logic [INDEX_WIDTH+DIM_WIDTH-1:0]     prod_i;

    always_comb
    begin
        for (int k = 0; k < MAX_RANK; k++)
        begin
            perm_ax[k] = tti_pkg::PERM_ENTRY_WIDTH'(perm_reg >> (2 * k));
        end
    end

    always_comb
    begin
        if (rank_reg == '0)
        begin
            rank_eff = RW'(1);
        end
        else if (int'(rank_reg) > MAX_RANK)
        begin
            rank_eff = RW'(MAX_RANK);
        end
        else
        begin
            rank_eff = RW'(rank_reg);
        end
    end

    always_comb
    begin
        logic [MAX_RANK-1:0] seen;
        seen      = '0;
        perm_ok_c = 1'b1;
        for (int i = 0; i < MAX_RANK; i++)
        begin
            if (i < int'(rank_eff))
            begin
                if (int'(perm_ax[i]) >= int'(rank_eff))
                begin
                    perm_ok_c = 1'b0;
                end
                else if (((seen >> perm_ax[i]) & MAX_RANK'(1)) != '0)
                begin
                    perm_ok_c = 1'b0;
                end
                else
                begin
                    seen = seen | (MAX_RANK'(1) << perm_ax[i]);
                end
            end
        end
    end

    always_comb
    begin
        ext_o = DIM_WIDTH'(1);
        for (int k = 0; k < MAX_RANK; k++)
        begin
            if (int'(perm_ax[step_reg]) == k)
            begin
                ext_o = size_reg[k];
            end
        end
    end

    assign step_used  = int'(step_reg) < int'(rank_eff);
    assign prod_o     = PW'(acc_out_reg) * PW'(ext_o);
    assign prod_o_sat = (prod_o > PW'(SAT)) ? SAT : prod_o[INDEX_WIDTH:0];
    assign prod_i     = (INDEX_WIDTH + DIM_WIDTH)'(acc_in_reg)
                        * (INDEX_WIDTH + DIM_WIDTH)'(size_reg[step_reg]);

    // registers and sequencer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg    <= tti_pkg::RANK_WIDTH'(1);
            perm_reg    <= tti_pkg::PERM_RESET;
            for (int k = 0; k < MAX_RANK; k++)
            begin
                size_reg[k] <= DIM_WIDTH'(1);
            end
            active_reg  <= 1'b1;
            step_reg    <= SW'(MAX_RANK - 1);
            acc_out_reg <= (INDEX_WIDTH + 1)'(1);
            acc_in_reg  <= INDEX_WIDTH'(1);
        end
        else if (cfg_valid)
        begin
            if (cfg_index == tti_pkg::REG_RANK)
            begin
                rank_reg <= cfg_data[tti_pkg::RANK_WIDTH-1:0];
            end
            if (cfg_index == tti_pkg::REG_PERM)
            begin
                perm_reg <= cfg_data[tti_pkg::PERM_WIDTH-1:0];
            end
            for (int k = 0; k < MAX_RANK; k++)
            begin
                if (k < tti_pkg::NUM_SIZE_REGS
                    && int'(cfg_index) == int'(tti_pkg::REG_SIZE0) + k)
                begin
                    size_reg[k] <= cfg_data[DIM_WIDTH-1:0];
                end
            end
            active_reg  <= 1'b1;
            step_reg    <= SW'(MAX_RANK - 1);
            acc_out_reg <= (INDEX_WIDTH + 1)'(1);
            acc_in_reg  <= INDEX_WIDTH'(1);
        end
        else if (active_reg)
        begin
            if (step_used)
            begin
                acc_out_reg <= prod_o_sat;
                acc_in_reg  <= prod_i[INDEX_WIDTH-1:0];
            end
            if (step_reg == '0)
            begin
                active_reg <= 1'b0;
            end
            else
            begin
                step_reg <= step_reg - SW'(1);
            end
        end
    end

    // stride tables, written by the sequencer
    always_ff @(posedge clk)
    begin
        if (active_reg && !cfg_valid)
        begin
            out_pitch_reg[step_reg] <= step_used ? acc_out_reg : SAT;
            in_pitch_reg[step_reg]  <= acc_in_reg;
            if (step_reg == '0)
            begin
                count_reg   <= prod_o_sat;
                perm_ok_reg <= perm_ok_c;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_RANK; i++)
        begin
            in_weight[i] = '0;
            for (int k = 0; k < MAX_RANK; k++)
            begin
                if (int'(perm_ax[i]) == k)
                begin
                    in_weight[i] = in_pitch_reg[k];
                end
            end
            out_pitch[i] = out_pitch_reg[i];
        end
    end

    assign count        = count_reg;
    assign stat.busy    = active_reg;
    assign stat.perm_ok = perm_ok_reg;

endmodule

// ===== hdl/tti_cell.sv =====
// One quotient-bit cell of the index chain: trial-subtract a shifted output stride
// and add the matching shifted source weight. Depends on tti_pkg.
module tti_cell #(
    parameter int INDEX_WIDTH = tti_pkg::INDEX_WIDTH_DEF,
    parameter int DIM_WIDTH   = tti_pkg::DIM_WIDTH_DEF,
    parameter int SHIFT       = 0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tti_pkg::ctl_t          ctl_in,
    input  logic [INDEX_WIDTH-1:0] rem_in,
    input  logic [INDEX_WIDTH-1:0] src_in,
    input  logic [INDEX_WIDTH:0]   stride,
    input  logic [INDEX_WIDTH-1:0] weight,
    output tti_pkg::ctl_t          ctl_out,
    output logic [INDEX_WIDTH-1:0] rem_out,
    output logic [INDEX_WIDTH-1:0] src_out
);

    localparam int TW = INDEX_WIDTH + 1 + DIM_WIDTH;

    tti_pkg::ctl_t          ctl_reg;
    logic [INDEX_WIDTH-1:0] rem_reg;
    logic [INDEX_WIDTH-1:0] src_reg;
    logic [TW-1:0]          trial;
    logic                   fits;
    logic [INDEX_WIDTH-1:0] step_w;

    assign trial  = TW'(stride) << SHIFT;
    assign fits   = trial <= TW'(rem_in);
    assign step_w = weight << SHIFT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= fits ? (rem_in - trial[INDEX_WIDTH-1:0]) : rem_in;
        src_reg <= fits ? (src_in + step_w) : src_in;
    end

    assign ctl_out = ctl_reg;
    assign rem_out = rem_reg;
    assign src_out = src_reg;

endmodule

// ===== hdl/tensor_transpose_index_map_top.sv =====
// Transpose index mapper: one source index per cycle while busy is low. A start is
// registered at entry, passes the cell chain and is registered again as done; a new word
// may start every cycle while busy is low. The cell chain resolves one coordinate bit
// per cell, outermost axis first. After reset and after every configuration write, busy
// stays high while the stride sequencer rebuilds its tables; start is refused then.
// Reset leaves rank 1, unit extents and the identity permutation; done cannot be stalled.
module tensor_transpose_index_map_top #(
    parameter int MAX_RANK    = tti_pkg::MAX_RANK_DEF,
    parameter int INDEX_WIDTH = tti_pkg::INDEX_WIDTH_DEF,
    parameter int DIM_WIDTH   = tti_pkg::DIM_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [INDEX_WIDTH-1:0]              out_index,
    output logic                                done,
    output logic [INDEX_WIDTH-1:0]              src_index,
    output logic [1:0]                          status,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tti_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [((DIM_WIDTH > tti_pkg::PERM_WIDTH) ? DIM_WIDTH
                   : tti_pkg::PERM_WIDTH)-1:0]  cfg_data
);

    localparam int NCELL = MAX_RANK * DIM_WIDTH;

    tti_pkg::cfg_stat_t     stat;
    logic [INDEX_WIDTH:0]   count;
    logic [INDEX_WIDTH:0]   out_pitch [MAX_RANK];
    logic [INDEX_WIDTH-1:0] in_weight [MAX_RANK];

    logic                   in_valid_reg;
    logic [INDEX_WIDTH-1:0] in_idx_reg;
    logic [1:0]             entry_status;

    tti_pkg::ctl_t          ctl_w [NCELL+1];
    logic [INDEX_WIDTH-1:0] rem_w [NCELL+1];
    logic [INDEX_WIDTH-1:0] src_w [NCELL+1];

    logic                   done_reg;
    logic [INDEX_WIDTH-1:0] src_index_reg;
    logic [1:0]             status_reg;

    tti_cfg #(
        .MAX_RANK    (MAX_RANK),
        .INDEX_WIDTH (INDEX_WIDTH),
        .DIM_WIDTH   (DIM_WIDTH)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .stat       (stat),
        .count      (count),
        .out_pitch  (out_pitch),
        .in_weight  (in_weight)
    );

    assign busy      = stat.busy;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !stat.busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !stat.busy)
        begin
            in_idx_reg <= out_index;
        end
    end

    always_comb
    begin
        if (!stat.perm_ok)
        begin
            entry_status = tti_pkg::ST_BAD_PERM;
        end
        else if ({1'b0, in_idx_reg} >= count)
        begin
            entry_status = tti_pkg::ST_RANGE;
        end
        else
        begin
            entry_status = tti_pkg::ST_OK;
        end
    end

    assign ctl_w[0].valid  = in_valid_reg;
    assign ctl_w[0].status = entry_status;
    assign rem_w[0]        = in_idx_reg;
    assign src_w[0]        = '0;

    for (genvar k = 0; k < NCELL; k++)
    begin : g_cell
        tti_cell #(
            .INDEX_WIDTH (INDEX_WIDTH),
            .DIM_WIDTH   (DIM_WIDTH),
            .SHIFT       (DIM_WIDTH - 1 - (k % DIM_WIDTH))
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl_in  (ctl_w[k]),
            .rem_in  (rem_w[k]),
            .src_in  (src_w[k]),
            .stride  (out_pitch[k / DIM_WIDTH]),
            .weight  (in_weight[k / DIM_WIDTH]),
            .ctl_out (ctl_w[k+1]),
            .rem_out (rem_w[k+1]),
            .src_out (src_w[k+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl_w[NCELL].valid;
        end
    end

    // drop the sum on any error
    always_ff @(posedge clk)
    begin
        status_reg    <= ctl_w[NCELL].status;
        src_index_reg <= (ctl_w[NCELL].status == tti_pkg::ST_OK) ? src_w[NCELL] : '0;
    end

    assign done      = done_reg;
    assign src_index = src_index_reg;
    assign status    = status_reg;

    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##(NCELL + 2) done)
        else $error("word lost in the cell chain");

    a_err_zero : assert property (@(posedge clk) disable iff (!rst_n)
        done && status != tti_pkg::ST_OK |-> src_index == '0)
        else $error("error word carries a nonzero source index");

    a_cfg_busy : assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> busy)
        else $error("start open before strides were rebuilt");

endmodule
